@@ design/kxr_pkg.sv @@
// Shared constants, types and the base decoder for the k-mer extractor.
package kxr_pkg;

    localparam int MAX_K  = 31;
    localparam int KW     = $clog2(MAX_K + 1);
    localparam int CODE_W = 2 * MAX_K;
    localparam int SEQ_W  = 32;
    localparam int POS_W  = 32;

    typedef enum logic [0:0] {
        REG_KMER_LEN     = 1'b0,
        REG_EMIT_REVCOMP = 1'b1
    } kxr_reg_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        code;
    } kxr_base_t;

    // One finished k-mer pair, as handed to the output stage
    typedef struct packed {
        logic [CODE_W-1:0] fwd;
        logic [CODE_W-1:0] rc;
        logic [SEQ_W-1:0]  seq;
        logic [POS_W-1:0]  pos;
        logic              has_rc;
    } kxr_item_t;

    function automatic kxr_base_t kxr_decode(input logic [7:0] c);
        kxr_base_t b;
        b.valid = 1'b1;
        b.code  = 2'd0;
        case (c) inside
            8'h41, 8'h61:               b.code = 2'd0;  // A a
            8'h43, 8'h63:               b.code = 2'd1;  // C c
            8'h47, 8'h67:               b.code = 2'd2;  // G g
            8'h54, 8'h74, 8'h55, 8'h75: b.code = 2'd3;  // T t U u
            default:                    b.valid = 1'b0;
        endcase
        return b;
    endfunction

endpackage

@@ design/kxr_cell.sv @@
// One window cell: holds one 2-bit base and passes it to the next cell on a shift.
module kxr_cell
    import kxr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic [1:0] base_in,
    output logic [1:0] base_next,
    output logic [1:0] base_q
);

    logic [1:0] base_reg;

    assign base_next = shift ? base_in : base_reg;
    assign base_q    = base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 2'd0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

endmodule

@@ design/kxr_out.sv @@
// Output stage: holds one k-mer pair and delivers one or two result transfers.
module kxr_out
    import kxr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  kxr_item_t               item,
    output logic                    free,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CODE_W-1:0]       out_code,
    output logic [SEQ_W-1:0]        out_seq,
    output logic [POS_W-1:0]        out_pos,
    output logic                    out_rc,
    output logic                    out_last
);

    kxr_item_t item_reg;
    logic      valid_reg, valid_next;
    logic      phase_reg, phase_next;
    logic      pop;

    assign out_valid = valid_reg;
    assign out_code  = phase_reg ? item_reg.rc : item_reg.fwd;
    assign out_seq   = item_reg.seq;
    assign out_pos   = item_reg.pos;
    assign out_rc    = phase_reg;
    assign out_last  = phase_reg | ~item_reg.has_rc;

    assign pop  = valid_reg & out_ready;
    // slot frees when empty or when its final transfer goes out now
    assign free = ~valid_reg | (pop & out_last);

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (pop)
        begin
            if (out_last)
            begin
                valid_next = 1'b0;
                phase_next = 1'b0;
            end
            else
            begin
                phase_next = 1'b1;
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    a_phase_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (valid_reg && item_reg.has_rc))
        else $error("second result pending without a held pair");

    a_rc_follows_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !out_last) |=> (valid_reg && phase_reg))
        else $error("reverse-complement result lost after forward transfer");

    a_no_palindrome: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && phase_reg) |-> (item_reg.rc != item_reg.fwd))
        else $error("palindromic k-mer emitted twice");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("held pair overwritten before delivery");

endmodule

@@ design/kmer_extract_revcomp.sv @@
// Top level of the rolling two-bit k-mer extractor with reverse complement.
// One base enters per clock as a transfer on s_* while the output slot is free; a row
// of 31 two-bit cells holds the newest bases and shifts on every valid base. The
// forward k-mer and its reverse complement are selected from the cells in the same
// cycle and land in a one-pair output slot, which takes the next base while its final
// result transfer goes out. A base that makes one result sustains one base per cycle;
// a base that makes both results holds the input while the forward one goes out, as
// the output port moves one result per cycle. There is no clearing pass after reset.
module kmer_extract_revcomp
    import kxr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [KW-1:0]     cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // base_char[7:0], seq_number[39:8]
    input  logic              s_tuser,   // seq_first
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [127:0]      m_tdata,   // kmer_code[61:0], kmer_seq[93:62],
                                         // kmer_pos[125:94], zero[127:126]
    output logic              m_tuser,   // is_revcomp
    output logic              m_tlast
);

    logic [KW-1:0]    kmer_len_reg;
    logic             emit_rc_reg;
    logic [KW-1:0]    run_reg, run_next;
    logic [POS_W-1:0] index_reg, index_next;

    logic [7:0]       base_char;
    logic [SEQ_W-1:0] seq_number;
    logic             accept;
    kxr_base_t        base;
    logic [KW-1:0]    k_eff;
    logic [KW-1:0]    run_start;
    logic [POS_W-1:0] pos;
    logic             emit;
    logic             shift;

    logic [1:0]        cell_next [MAX_K];
    logic [1:0]        cell_q    [MAX_K];
    logic [CODE_W-1:0] fwd_code, rc_code;
    kxr_item_t         item;
    logic              slot_free;
    logic [CODE_W-1:0] out_code;
    logic [SEQ_W-1:0]  out_seq;
    logic [POS_W-1:0]  out_pos;

    assign base_char  = s_tdata[7:0];
    assign seq_number = s_tdata[39:8];
    assign s_tready   = slot_free;
    assign accept     = s_tvalid & s_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_len_reg <= KW'(15);
            emit_rc_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KMER_LEN:     kmer_len_reg <= cfg_data;
                REG_EMIT_REVCOMP: emit_rc_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign k_eff = (kmer_len_reg == '0) ? KW'(1) : kmer_len_reg;
    assign base  = kxr_decode(base_char);
    assign shift = accept & base.valid;

    // run count and position, restarted on the first base of a sequence
    always_comb
    begin
        run_start  = s_tuser ? '0 : run_reg;
        pos        = s_tuser ? '0 : index_reg;
        run_next   = run_reg;
        index_next = index_reg;
        if (accept)
        begin
            index_next = (pos == '1) ? pos : pos + POS_W'(1);
            if (!base.valid)
            begin
                run_next = '0;
            end
            else if (run_start < KW'(MAX_K))
            begin
                run_next = run_start + KW'(1);
            end
            else
            begin
                run_next = run_start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            index_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            index_reg <= index_next;
        end
    end

    // base window: cell 0 holds the newest base
    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        kxr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift),
            .base_in   ((i == 0) ? base.code : cell_q[(i == 0) ? 0 : i - 1]),
            .base_next (cell_next[i]),
            .base_q    (cell_q[i])
        );
    end

    // select the k newest bases; the complement reads the cells in reverse order
    always_comb
    begin
        fwd_code = '0;
        rc_code  = '0;
        for (int j = 0; j < MAX_K; j++)
        begin
            if (KW'(j) < k_eff)
            begin
                fwd_code[2*j +: 2] = cell_next[j];
                rc_code[2*j +: 2]  = ~cell_next[k_eff - KW'(j) - KW'(1)];
            end
        end
    end

    assign emit = shift & (run_next >= k_eff);

    assign item.fwd    = fwd_code;
    assign item.rc     = rc_code;
    assign item.seq    = seq_number;
    assign item.pos    = pos - POS_W'(k_eff - KW'(1));
    assign item.has_rc = emit_rc_reg & (rc_code != fwd_code);

    kxr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .item      (item),
        .free      (slot_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (out_code),
        .out_seq   (out_seq),
        .out_pos   (out_pos),
        .out_rc    (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_pos, out_seq, out_code};

endmodule

@@ sim/kmer_check.sv @@
// Checker for the k-mer extractor: rolls its own windows and compares every k-mer transfer.
module kmer_check
    import kxr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [0:0]    cfg_index,
    input  logic [KW-1:0] cfg_data,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [39:0]   s_tdata,   // base_char[7:0], seq_number[39:8]
    input  logic          s_tuser,   // seq_first
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [127:0]  m_tdata,   // kmer_code[61:0], kmer_seq[93:62], kmer_pos[125:94]
    input  logic          m_tuser,   // is_revcomp
    input  logic          m_tlast,
    output int            errors,
    output int            pending,
    output int            kmers,
    output int            rc_kmers,
    output int            palindromes
);

    localparam logic [KW-1:0] KLEN_RESET = KW'(15);

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [SEQ_W-1:0]  seq;
        logic [POS_W-1:0]  pos;
        logic              rc;
        logic              last;
    } kmer_t;

    kmer_t             kmer_queue[$];
    logic [KW-1:0]     klen;
    logic              rc_on;
    logic [CODE_W-1:0] fwd_win;
    logic [CODE_W-1:0] rc_win;
    int unsigned       run_len;
    logic [POS_W-1:0]  next_pos;
    kmer_t             want;
    kmer_t             got;

    // {valid, two-bit code}
    function automatic logic [2:0] nt_code(input logic [7:0] ch);
        case (ch)
            "A", "a":           return 3'b100;
            "C", "c":           return 3'b101;
            "G", "g":           return 3'b110;
            "T", "t", "U", "u": return 3'b111;
            default:            return 3'b000;
        endcase
    endfunction

    // append one expected k-mer at the tail
    task automatic add_kmer(input kmer_t r);
        kmer_queue.insert(kmer_queue.size(), r);
    endtask

    task automatic roll_base(input logic [7:0] ch, input logic first,
                             input logic [SEQ_W-1:0] seqn);
        logic [2:0]        nt;
        int unsigned       k;
        logic [63:0]       kmask;
        logic [CODE_W-1:0] fwd;
        logic [CODE_W-1:0] rc;
        logic [POS_W-1:0]  pos;
        kmer_t             r;
        k = (klen == 0) ? 1 : int'(klen);
        if (k > MAX_K)
            k = MAX_K;
        if (first)
        begin
            fwd_win  = '0;
            rc_win   = '0;
            run_len  = 0;
            next_pos = '0;
        end
        pos = next_pos;
        // hold the position at its maximum
        if (next_pos != '1)
            next_pos = next_pos + POS_W'(1);
        nt = nt_code(ch);
        if (!nt[2])
        begin
            fwd_win = '0;
            rc_win  = '0;
            run_len = 0;
            return;
        end
        fwd_win = {fwd_win[CODE_W-3:0], nt[1:0]};
        rc_win  = {~nt[1:0], rc_win[CODE_W-1:2]};
        if (run_len < MAX_K)
            run_len++;
        if (run_len >= k)
        begin
            kmask  = (64'd1 << (2 * k)) - 64'd1;
            fwd    = CODE_W'(64'(fwd_win) & kmask);
            rc     = CODE_W'((64'(rc_win) >> (2 * (MAX_K - k))) & kmask);
            r.code = fwd;
            r.seq  = seqn;
            r.pos  = pos - POS_W'(k - 1);
            r.rc   = 1'b0;
            r.last = 1'b1;
            if (rc_on && rc != fwd)
            begin
                r.last = 1'b0;
                add_kmer(r);
                r.code = rc;
                r.rc   = 1'b1;
                r.last = 1'b1;
            end
            else if (rc_on)
                palindromes++;
            add_kmer(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen        = KLEN_RESET;
            rc_on       = 1'b1;
            fwd_win     = '0;
            rc_win      = '0;
            run_len     = 0;
            next_pos    = '0;
            kmer_queue.delete();
            errors      = 0;
            pending     = 0;
            kmers       = 0;
            rc_kmers    = 0;
            palindromes = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (kxr_reg_t'(cfg_index))
                    REG_KMER_LEN:     klen  = cfg_data;
                    REG_EMIT_REVCOMP: rc_on = cfg_data[0];
                    default:          ;
                endcase
            end
            if (s_tvalid && s_tready)
                roll_base(s_tdata[7:0], s_tuser, s_tdata[39:8]);
            if (m_tvalid && m_tready)
            begin
                got.code = m_tdata[61:0];
                got.seq  = m_tdata[93:62];
                got.pos  = m_tdata[125:94];
                got.rc   = m_tuser;
                got.last = m_tlast;
                if (kmer_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected k-mer: code=%h seq=%h pos=%0d rc=%b last=%b",
                                 got.code, got.seq, got.pos, got.rc, got.last);
                end
                else
                begin
                    want = kmer_queue.pop_front();
                    kmers++;
                    if (want.rc)
                        rc_kmers++;
                    if (got.code !== want.code || got.seq !== want.seq ||
                        got.pos !== want.pos || got.rc !== want.rc || got.last !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("k-mer mismatch: want code=%h seq=%h pos=%0d rc=%b last=%b",
                                     want.code, want.seq, want.pos, want.rc, want.last);
                            $display("                 got code=%h seq=%h pos=%0d rc=%b last=%b",
                                     got.code, got.seq, got.pos, got.rc, got.last);
                        end
                    end
                end
            end
            pending = kmer_queue.size();
        end
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for the k-mer extractor: clock, reset, base stimulus and the verdict.
module tb;
    import kxr_pkg::*;

    localparam int HOLD_CYCLES = 64;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [0:0]    cfg_index = REG_KMER_LEN;
    logic [KW-1:0] cfg_data = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [39:0]   s_tdata = '0;   // base_char[7:0], seq_number[39:8]
    logic          s_tuser = 1'b0; // seq_first
    logic          m_tvalid;
    logic          m_tready;
    logic [127:0]  m_tdata;        // kmer_code[61:0], kmer_seq[93:62], kmer_pos[125:94]
    logic          m_tuser;        // is_revcomp
    logic          m_tlast;

    int            errors;
    int            pending;
    int            kmers;
    int            rc_kmers;
    int            palindromes;

    bit            src_idle = 1'b1;
    bit            rx_idle = 1'b1;
    bit            hold_req = 1'b0;
    int            sent = 0;
    int            settings = 0;
    logic [7:0]    nt_chars [0:9] = '{"A", "C", "G", "T", "a", "c", "g", "t", "U", "u"};
    int            ph_klen [0:7] = '{1, 31, 0, 2, 7, 31, 15, 3};
    bit            ph_rc [0:7]   = '{1, 1, 0, 1, 1, 0, 1, 1};

    kmer_extract_revcomp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    kmer_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .pending     (pending),
        .kmers       (kmers),
        .rc_kmers    (rc_kmers),
        .palindromes (palindromes)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: ready in random stretches, short stalls, and one long hold on request
    initial
    begin
        int n;
        forever
        begin
            if (hold_req)
            begin
                m_tready = 1'b0;
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 4) == 0)
            begin
                m_tready = 1'b0;
                n = $urandom_range(1, 3);
            end
            else
            begin
                m_tready = 1'b1;
                n = $urandom_range(1, 8);
            end
            repeat (n) @(negedge clk);
        end
    end

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic put_base(input logic [7:0] ch, input logic first, input logic [31:0] seqn);
        int gap;
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {seqn, ch};
        s_tuser  = first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic set_reg(input kxr_reg_t idx, input logic [KW-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        settings++;
    endtask

    // Drop valid and wait out every pending k-mer plus the output slot
    task automatic settle();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_base();
        if ($urandom_range(0, 99) < 4)
            return 8'($urandom_range(0, 255));
        return nt_chars[$urandom_range(0, 9)];
    endfunction

    task automatic send_seq(input int len);
        logic [31:0] seqn;
        logic        first;
        int          sel;
        int          i;
        sel   = $urandom_range(0, 9);
        seqn  = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
        // now and then run on from the previous sequence
        first = ($urandom_range(0, 9) != 0);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                seqn = $urandom;
            put_base(pick_base(), first && i == 0, seqn);
        end
    endtask

    initial
    begin
        string       seq_text;
        int          i;
        int          ph;
        int          n;
        int          len;
        int          keff;
        logic [4:0]  klen;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: k of 15 with reverse complement, every accepted letter
        seq_text = "CGTacgtUuAACCGGTT";
        put_base("A", 1'b1, 32'h0);
        for (i = 0; i < seq_text.len(); i++)
            put_base(seq_text[i], 1'b0, 32'h0);
        put_base(8'hFF, 1'b0, 32'h0);
        put_base(8'h00, 1'b0, 32'h0);

        // short k: palindromes and a break in the run
        settle();
        set_reg(REG_KMER_LEN, 5'd2);
        put_base("A", 1'b1, 32'hFFFF_FFFF);
        put_base("T", 1'b0, 32'hFFFF_FFFF);
        put_base("G", 1'b0, 32'hFFFF_FFFF);
        put_base("C", 1'b0, 32'hFFFF_FFFF);
        put_base("N", 1'b0, 32'hFFFF_FFFF);
        put_base("g", 1'b0, 32'hFFFF_FFFF);
        put_base("c", 1'b0, 32'hFFFF_FFFF);

        for (ph = 0; ph < 8; ph++)
        begin
            settle();
            if (ph == 7)
            begin
                src_idle = 1'b0;
                rx_idle  = 1'b0;
            end
            klen = (ph == 6) ? 5'($urandom_range(0, 31)) : 5'(ph_klen[ph]);
            keff = (klen == 0) ? 1 : int'(klen);
            set_reg(REG_KMER_LEN, klen);
            set_reg(REG_EMIT_REVCOMP, KW'(ph_rc[ph]));
            if (ph == 3)
                hold_req = 1'b1;
            n = 0;
            while (n < 125)
            begin
                len = $urandom_range(keff / 2 + 1, keff + 40);
                send_seq(len);
                n += len;
            end
        end
        settle();

        $display("Sent %0d bases through %0d register writes: k of 0, 1, 2, 31 and others,",
                 sent, settings);
        $display("complements on and off; %0d k-mers, %0d complements, %0d palindromes.",
                 kmers, rc_kmers, palindromes);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
